/* rtl/core/drp_pkg.sv */
// ----------------------------------------------------------------------------
// drp_pkg
// shared types, widths and register codes for the disparity reprojection core
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

  localparam int DISP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int FOC_W   = 20;
  localparam int BASE_W  = 18;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;

  localparam int DISP_FRAC_BITS = 4;
  localparam int PIX_FRAC_BITS  = 8;

  localparam int DDEN_W = DISP_W + DISP_FRAC_BITS;
  localparam int OFF_W  = PIX_W + PIX_FRAC_BITS;
  localparam int BMAG_W = BASE_W;
  localparam int ZMAG_W = FOC_W + BMAG_W;
  localparam int NUM_W  = OFF_W + ZMAG_W;
  localparam int DEN_W  = DDEN_W + FOC_W;
  localparam int QUO_W  = COORD_W - 1;
  localparam int WIDE_W = DEN_W + QUO_W;

  localparam logic [IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_BASELINE = 3'd4;

  localparam logic [FOC_W-1:0]  FOCAL_X_RST  = 20'd179200;
  localparam logic [FOC_W-1:0]  FOCAL_Y_RST  = 20'd179200;
  localparam logic [FOC_W-1:0]  CENTER_X_RST = 20'd163840;
  localparam logic [FOC_W-1:0]  CENTER_Y_RST = 20'd92160;
  localparam logic [BASE_W-1:0] BASELINE_RST = 18'd7864;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_SAT
  } res_mode_t;

  typedef struct packed {
    logic [FOC_W-1:0]  focal_x;
    logic [FOC_W-1:0]  focal_y;
    logic [FOC_W-1:0]  center_x;
    logic [FOC_W-1:0]  center_y;
    logic [BASE_W-1:0] baseline;
  } drp_cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    res_mode_t        mode;
    logic             neg;
  } drp_op_t;

endpackage

`default_nettype wire

/* rtl/core/drp_prep.sv */
// ----------------------------------------------------------------------------
// drp_prep
// three-stage operand builder: offsets, depth products, y numerator/denominator
// ----------------------------------------------------------------------------
`default_nettype none

module drp_prep (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic                        in_valid,
  input  wire logic [drp_pkg::DISP_W-1:0]  disparity,
  input  wire logic [drp_pkg::PIX_W-1:0]   column,
  input  wire logic [drp_pkg::PIX_W-1:0]   row,
  input  wire drp_pkg::drp_cfg_t           cfg,
  output logic                             out_valid,
  output drp_pkg::drp_op_t                 op_x,
  output drp_pkg::drp_op_t                 op_y,
  output drp_pkg::drp_op_t                 op_z
);
  import drp_pkg::*;

  logic              v1, v2;
  logic [DDEN_W-1:0] dden1, dden2;
  logic [OFF_W-1:0]  xoff1, yoff1, yoff2;
  logic              xneg1, yneg1, xneg2, yneg2, bneg1, bneg2;
  logic [BMAG_W-1:0] bmag1;
  logic [ZMAG_W-1:0] zmag2, xprod2;

  logic [OFF_W-1:0]  px, py;
  logic [BMAG_W-1:0] bmag;
  logic [NUM_W-1:0]  ymag;
  logic [DEN_W-1:0]  yden;

  // stage 1: pixel offsets and baseline magnitude
  always_comb begin
    px   = {column, PIX_FRAC_BITS'(0)};
    py   = {row, PIX_FRAC_BITS'(0)};
    bmag = cfg.baseline[BASE_W-1] ? BMAG_W'(~cfg.baseline + 1'b1) : cfg.baseline;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid && (disparity != '0);
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dden1 <= {disparity, DISP_FRAC_BITS'(0)};
      xneg1 <= px < cfg.center_x;
      xoff1 <= (px >= cfg.center_x) ? px - cfg.center_x : cfg.center_x - px;
      yneg1 <= py < cfg.center_y;
      yoff1 <= (py >= cfg.center_y) ? py - cfg.center_y : cfg.center_y - py;
      bmag1 <= bmag;
      bneg1 <= cfg.baseline[BASE_W-1];
    end
  end

  // stage 2: depth and x products
  always_ff @(posedge clk) begin
    if (advance) begin
      zmag2  <= ZMAG_W'(cfg.focal_x) * ZMAG_W'(bmag1);
      xprod2 <= ZMAG_W'(xoff1) * ZMAG_W'(bmag1);
      dden2  <= dden1;
      yoff2  <= yoff1;
      yneg2  <= yneg1;
      xneg2  <= xneg1;
      bneg2  <= bneg1;
    end
  end

  // stage 3: y numerator and denominator
  always_comb begin
    ymag = NUM_W'(yoff2) * NUM_W'(zmag2);
    yden = DEN_W'(dden2) * DEN_W'(cfg.focal_y);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_z.num  <= NUM_W'(zmag2);
      op_z.den  <= DEN_W'(dden2);
      op_z.mode <= MODE_DIV;
      op_z.neg  <= bneg2;

      op_x.num  <= NUM_W'(xprod2);
      op_x.den  <= DEN_W'(dden2);
      op_x.mode <= (cfg.focal_x == '0) ? MODE_ZERO : MODE_DIV;
      op_x.neg  <= xneg2 ^ bneg2;

      op_y.num  <= ymag;
      op_y.den  <= yden;
      op_y.neg  <= yneg2 ^ bneg2;
      if (cfg.focal_y != '0) begin
        op_y.mode <= MODE_DIV;
      end else if (ymag == '0) begin
        op_y.mode <= MODE_ZERO;
      end else begin
        op_y.mode <= MODE_SAT;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/drp_div.sv */
// ----------------------------------------------------------------------------
// drp_div
// pipelined restoring divider, one quotient bit per stage, round and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module drp_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         in_valid,
  input  wire drp_pkg::drp_op_t             in_op,
  output logic                              out_valid,
  output logic [drp_pkg::COORD_W-1:0]       out_value
);
  import drp_pkg::*;

  logic [QUO_W:0]   vld;
  logic [QUO_W:0]   ovf;
  logic [QUO_W:0]   neg;
  res_mode_t        mode [QUO_W+1];
  logic [NUM_W-1:0] rem  [QUO_W+1];
  logic [DEN_W-1:0] den  [QUO_W+1];
  logic [QUO_W-1:0] quo  [QUO_W+1];

  logic             round_up;
  logic [COORD_W-1:0] qr;
  logic [COORD_W-1:0] value;

  // stage 0: quotient overflow check
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0]  <= in_op.num;
      den[0]  <= in_op.den;
      quo[0]  <= '0;
      mode[0] <= in_op.mode;
      neg[0]  <= in_op.neg;
      ovf[0]  <= WIDE_W'(in_op.num) >= (WIDE_W'(in_op.den) << QUO_W);
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [WIDE_W-1:0] trial;
    logic              ge;

    always_comb begin
      trial = WIDE_W'(den[k-1]) << (QUO_W - k);
      ge    = WIDE_W'(rem[k-1]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k]  <= ge ? NUM_W'(WIDE_W'(rem[k-1]) - trial) : rem[k-1];
        quo[k]  <= quo[k-1] | (ge ? (QUO_W'(1) << (QUO_W - k)) : '0);
        den[k]  <= den[k-1];
        mode[k] <= mode[k-1];
        neg[k]  <= neg[k-1];
        ovf[k]  <= ovf[k-1];
      end
    end
  end

  // round half away from zero, then clamp
  always_comb begin
    round_up = {rem[QUO_W], 1'b0} >= (NUM_W + 1)'(den[QUO_W]);
    qr       = COORD_W'(quo[QUO_W]) + COORD_W'(round_up);
    unique case (mode[QUO_W])
      MODE_ZERO: value = '0;
      MODE_SAT:  value = neg[QUO_W] ? SAT_NEG : SAT_POS;
      default: begin
        if (neg[QUO_W]) begin
          value = ovf[QUO_W] ? SAT_NEG : COORD_W'(~qr + 1'b1);
        end else begin
          value = (ovf[QUO_W] || qr[COORD_W-1]) ? SAT_POS : qr;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/disparity_to_point_reprojection.sv */
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// stereo disparity pixel to pinhole 3d point, signed q16.16, saturated
//
//   channel   dir  payload (lsb first)
//   s_*       in   disparity[15:0] column[27:16] row[39:28]
//   m_*       out  point_x[31:0] point_y[63:32] point_z[95:64]
//   cfg_*     in   register write, index 0..4
//
// one request per clock unless m_tready stalls; 3 operand stages, 32 divider
// stages (overflow check, then one quotient bit each), 1 output register
// zero disparity consumes a slot and produces nothing
// a stall on m_tready freezes the whole pipeline; s_tready follows it
// synchronous reset clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_to_point_reprojection (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [39:0]                 s_tdata,   // disparity, column, row
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [95:0]                      m_tdata,   // point_x, point_y, point_z
  input  wire logic                        cfg_we,
  input  wire logic [drp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [drp_pkg::CFG_W-1:0]   cfg_data
);
  import drp_pkg::*;

  drp_cfg_t cfg;
  logic     advance;
  logic     prep_valid;
  logic     x_valid, y_valid;
  drp_op_t  op_x, op_y, op_z;
  logic [COORD_W-1:0] point_x, point_y, point_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= FOCAL_X_RST;
      cfg.focal_y  <= FOCAL_Y_RST;
      cfg.center_x <= CENTER_X_RST;
      cfg.center_y <= CENTER_Y_RST;
      cfg.baseline <= BASELINE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X:  cfg.focal_x  <= cfg_data;
        REG_FOCAL_Y:  cfg.focal_y  <= cfg_data;
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        REG_BASELINE: cfg.baseline <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  drp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_tvalid),
    .disparity (s_tdata[15:0]),
    .column    (s_tdata[27:16]),
    .row       (s_tdata[39:28]),
    .cfg       (cfg),
    .out_valid (prep_valid),
    .op_x      (op_x),
    .op_y      (op_y),
    .op_z      (op_z)
  );

  drp_div u_div_z (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (prep_valid),
    .in_op     (op_z),
    .out_valid (m_tvalid),
    .out_value (point_z)
  );

  drp_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (prep_valid),
    .in_op     (op_x),
    .out_valid (x_valid),
    .out_value (point_x)
  );

  drp_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (prep_valid),
    .in_op     (op_y),
    .out_valid (y_valid),
    .out_value (point_y)
  );

  assign m_tdata = {point_z, point_y, point_x};

`ifndef SYNTHESIS
  a_z_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !cfg.baseline[BASE_W-1] && !cfg_we) |-> !point_z[COORD_W-1])
    else $error("depth negative with positive baseline");

  a_fx_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cfg.focal_x == '0 && !cfg_we) |-> (point_x == '0 && point_z == '0))
    else $error("x or z nonzero with zero focal_x");

  a_base_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cfg.baseline == '0 && !cfg_we) |-> (m_tdata == '0))
    else $error("point nonzero with zero baseline");

  a_lanes_step: assert property (@(posedge clk) disable iff (rst)
    (x_valid == m_tvalid) && (y_valid == m_tvalid))
    else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

/* verif/disparity_to_point_reprojection_test.sv */
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_test
// Self-checking bench for the disparity reprojection core. Pixels are sent on
// the request stream in random bursts. Each accepted nonzero-disparity request
// is predicted against a local copy of the camera registers. The result stream
// stalls on its own pattern; every returned point is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module disparity_to_point_reprojection_test;
  import drp_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [39:0]       s_tdata;   // disparity, column, row
  logic              m_tvalid;
  logic              m_tready;
  logic [95:0]       m_tdata;   // point_x, point_y, point_z
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  logic [39:0]       pixel_q[$];
  point_t            point_q[$];
  int                errors;
  int                cycles;
  int                burst_left;
  int                gap_left;
  int                stall_mode;

  logic [FOC_W-1:0]  fx_r, fy_r, cx_r, cy_r;
  logic [BASE_W-1:0] base_r;

  disparity_to_point_reprojection u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] round_clamp(longint unsigned mag, bit neg,
                                               longint unsigned den);
    longint unsigned q, r;
    q = mag / den;
    r = mag % den;
    if (r >= den - r) q++;
    if (neg) begin
      if (q >= 64'h8000_0000) return SAT_NEG;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) return SAT_POS;
    return 32'(q);
  endfunction

  function automatic longint unsigned pixel_offset(logic [11:0] pix, logic [19:0] ctr,
                                                   output bit neg);
    longint unsigned p;
    p = longint'(pix) << 8;
    neg = p < ctr;
    return neg ? longint'(ctr) - p : p - ctr;
  endfunction

  function automatic point_t reproject(logic [11:0] u, logic [11:0] v, logic [15:0] d);
    point_t pt;
    longint b, xoff, yoff;
    longint unsigned bmag, dden, zmag, ymag;
    bit bneg, xneg, yneg;
    b = $signed(base_r);
    bneg = b < 0;
    bmag = bneg ? -b : b;
    dden = 16 * longint'(d);
    zmag = longint'(fx_r) * bmag;
    pt.z = round_clamp(zmag, bneg, dden);
    xoff = pixel_offset(u, cx_r, xneg);
    pt.x = (fx_r == 0) ? '0 : round_clamp(xoff * bmag, xneg != bneg, dden);
    yoff = pixel_offset(v, cy_r, yneg);
    ymag = yoff * zmag;
    if (fy_r == 0) pt.y = (ymag == 0) ? '0 : ((yneg != bneg) ? SAT_NEG : SAT_POS);
    else pt.y = round_clamp(ymag, yneg != bneg, dden * fy_r);
    return pt;
  endfunction

  // request driver and prediction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready && s_tdata[15:0] != 0)
        point_q.push_back(reproject(s_tdata[27:16], s_tdata[39:28], s_tdata[15:0]));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pixel_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern and checking
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (point_q.size() == 0) begin
          $error("unexpected point %h", m_tdata);
          errors++;
        end else begin
          point_t exp_pt;
          exp_pt = point_q.pop_front();
          if (m_tdata[31:0] !== exp_pt.x) begin
            $error("point_x expected %h got %h", exp_pt.x, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== exp_pt.y) begin
            $error("point_y expected %h got %h", exp_pt.y, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[95:64] !== exp_pt.z) begin
            $error("point_z expected %h got %h", exp_pt.z, m_tdata[95:64]);
            errors++;
          end
        end
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (cycles % 16) < 11;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FOCAL_X:  fx_r = val;
      REG_FOCAL_Y:  fy_r = val;
      REG_CENTER_X: cx_r = val;
      REG_CENTER_Y: cy_r = val;
      REG_BASELINE: base_r = val[BASE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [19:0] fx, logic [19:0] fy, logic [19:0] cx,
                            logic [19:0] cy, logic [19:0] b);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_BASELINE, b);
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || s_tvalid || point_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    stall_mode = $urandom_range(0, 2);
  endtask

  task automatic push_pixel(logic [15:0] d, logic [11:0] u, logic [11:0] v);
    pixel_q.push_back({v, u, d});
  endtask

  task automatic push_random(int n);
    logic [15:0] d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: d = 0;
        1, 2: d = 16'($urandom_range(1, 64));
        default: d = 16'($urandom_range(1, 65535));
      endcase
      push_pixel(d, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    stall_mode = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fx_r = FOCAL_X_RST;
    fy_r = FOCAL_Y_RST;
    cx_r = CENTER_X_RST;
    cy_r = CENTER_Y_RST;
    base_r = BASELINE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed pixels on reset camera
    push_pixel(16'd0, 12'd100, 12'd100);
    push_pixel(16'd1, 12'd0, 12'd0);
    push_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    push_pixel(16'd1, 12'hFFF, 12'd0);
    push_pixel(16'd16, 12'd640, 12'd360);
    push_pixel(16'h8000, 12'd0, 12'hFFF);
    push_pixel(16'd0, 12'hFFF, 12'hFFF);
    push_pixel(16'd3, 12'd639, 12'd361);
    wait_idle();

    // ignored register indexes must not disturb anything
    for (int i = REG_BASELINE + 1; i < 8; i++) write_reg(IDX_W'(i), 20'hFFFFF);
    push_pixel(16'd5, 12'd1, 12'd2);
    wait_idle();

    // zero focal lengths, extreme baselines and centers
    set_camera(20'd0, 20'd0, 20'hFFFFF, 20'd0, 20'h20000);
    push_pixel(16'd1, 12'd0, 12'd0);
    push_pixel(16'd1, 12'hFFF, 12'hFFF);
    push_pixel(16'hFFFF, 12'd7, 12'd0);
    wait_idle();
    set_camera(20'hFFFFF, 20'd0, 20'd0, 20'hFFFFF, 20'h1FFFF);
    push_pixel(16'd1, 12'hFFF, 12'hFFF);
    push_pixel(16'd1, 12'd0, 12'd0);
    push_pixel(16'hFFFF, 12'd0, 12'hFFF);
    wait_idle();
    set_camera(20'hFFFFF, 20'hFFFFF, 20'h80000, 20'h80000, 20'd0);
    push_pixel(16'd1, 12'd0, 12'hFFF);
    push_pixel(16'hFFFF, 12'hFFF, 12'd0);
    wait_idle();
    set_camera(20'd1, 20'd1, 20'd0, 20'd0, 20'h3FFFF);
    push_pixel(16'd1, 12'hFFF, 12'hFFF);
    push_pixel(16'hFFFF, 12'd1, 12'd1);
    wait_idle();

    // random phases with random and extreme cameras
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0)
        set_camera(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                   20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                   20'($urandom_range(0, 20'hFFFFF)));
      else
        set_camera(20'($urandom_range(20'h10000, 20'h40000)),
                   20'($urandom_range(20'h10000, 20'h40000)),
                   20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                   ($urandom_range(0, 1) ? 20'(20'h3FFFF - $urandom_range(0, 20000))
                                         : 20'($urandom_range(0, 20000))));
      push_random(130);
      wait_idle();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
